/* sv/catmull_rom_spline_eval_macros.svh */
// ----------------------------------------------------------------------------
// Catmull-Rom evaluator assertion macros
// Shared concurrent assertion forms, sampled on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_SPLINE_EVAL_MACROS_SVH
`define CATMULL_ROM_SPLINE_EVAL_MACROS_SVH

// implication checked every cycle
`define CRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain invariant
`define CRS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* sv/crs_pkg.sv */
// ----------------------------------------------------------------------------
// Catmull-Rom evaluator package
// Types, codes and sizes shared by the spline evaluator modules.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int CRS_MAX_POINTS = 64;
    localparam int CRS_IDX_W      = $clog2(CRS_MAX_POINTS);
    localparam int CRS_CNT_W      = 7;
    localparam int CRS_T_W        = 17;
    localparam int CRS_COEF_W     = 38;
    localparam int CRS_PROD_W     = CRS_COEF_W + CRS_T_W + 1;
    localparam int CRS_LATENCY    = 11;
    localparam int CRS_TAIL_DEPTH = 7;

    localparam logic       OP_WRITE      = 1'b0;
    localparam logic       OP_EVAL       = 1'b1;
    localparam logic       MODE_CLAMPED  = 1'b0;
    localparam logic       MODE_STANDARD = 1'b1;
    localparam logic       STATUS_OK     = 1'b0;
    localparam logic       STATUS_FEW    = 1'b1;
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_COUNT     = 2'd1;

    localparam logic [CRS_T_W-1:0] T_ONE = CRS_T_W'(65536);

    typedef struct packed {
        logic                operation;
        logic [5:0]          point_index;
        logic signed [31:0]  coord_x;
        logic signed [31:0]  coord_y;
        logic signed [31:0]  coord_z;
        logic [CRS_T_W-1:0]  curve_t;
    } crs_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               status;
    } crs_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } crs_point_t;

    typedef struct packed {
        logic                             valid;
        logic                             wr;
        logic                             few;
        logic [CRS_IDX_W-1:0]             widx;
        crs_point_t                       wdata;
        logic [3:0][CRS_IDX_W-1:0]        ridx;
        logic [CRS_T_W-1:0]               u;
    } crs_ctl_t;

    typedef struct packed {
        logic               valid;
        logic               few;
        logic [CRS_T_W-1:0] u;
    } crs_rd_t;

endpackage

/* sv/catmull_rom_spline_eval.sv */
// An evaluate transfer gives one result transfer; a point write gives none.
// Throughput: one transfer per cycle of either kind, busy stays low.
// Depth is set by the three Horner multiply / round-add steps after the table read.
// Reset clears the mode and count registers and the valid pipeline at once.
// Table entries hold nothing defined until written; no clearing pass.
// ----------------------------------------------------------------------------
// Catmull-Rom spline evaluator
// Point table plus a fully pipelined uniform Catmull-Rom evaluator in Q16.16.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval
    import crs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  crs_in_t              in_item,
    output logic                 done,
    output crs_out_t             result,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [CRS_CNT_W-1:0] cfg_data
);

    logic                 mode_reg;
    logic [CRS_CNT_W-1:0] count_reg;
    crs_ctl_t             ctl;
    crs_point_t [3:0]     pts;
    crs_rd_t              rd;
    logic [CRS_TAIL_DEPTH-1:0] v_reg, v_next;
    logic [CRS_TAIL_DEPTH-1:0] few_reg;
    logic signed [31:0]   ax, ay, az;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_CLAMPED;
            count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[0];
                REG_COUNT: count_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    crs_index u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (start && !busy),
        .in_item (in_item),
        .mode    (mode_reg),
        .count   (count_reg),
        .ctl     (ctl)
    );

    crs_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pts   (pts),
        .rd    (rd)
    );

    crs_axis u_ax (.clk(clk), .p0(pts[0].x), .p1(pts[1].x), .p2(pts[2].x), .p3(pts[3].x),
                   .u(rd.u), .pos(ax));
    crs_axis u_ay (.clk(clk), .p0(pts[0].y), .p1(pts[1].y), .p2(pts[2].y), .p3(pts[3].y),
                   .u(rd.u), .pos(ay));
    crs_axis u_az (.clk(clk), .p0(pts[0].z), .p1(pts[1].z), .p2(pts[2].z), .p3(pts[3].z),
                   .u(rd.u), .pos(az));

    assign v_next = {v_reg[CRS_TAIL_DEPTH-2:0], rd.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        few_reg <= {few_reg[CRS_TAIL_DEPTH-2:0], rd.few};
    end

    always_comb
    begin
        done = v_reg[CRS_TAIL_DEPTH-1];
        if (few_reg[CRS_TAIL_DEPTH-1])
        begin
            result = '{pos_x: '0, pos_y: '0, pos_z: '0, status: STATUS_FEW};
        end
        else
        begin
            result = '{pos_x: ax, pos_y: ay, pos_z: az, status: STATUS_OK};
        end
    end

endmodule

/* sv/crs_index.sv */
// ----------------------------------------------------------------------------
// Segment index stages
// Captures a transfer, scales t by the segment count, picks the four entries.
// ----------------------------------------------------------------------------
module crs_index
    import crs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  crs_in_t              in_item,
    input  logic                 mode,
    input  logic [CRS_CNT_W-1:0] count,
    output crs_ctl_t             ctl
);

    // stage 1
    logic                 v1_reg, op1_reg, mode1_reg;
    logic [CRS_IDX_W-1:0] widx1_reg;
    crs_point_t           pt1_reg;
    logic [CRS_T_W-1:0]   t1_reg;
    logic [CRS_CNT_W-1:0] n1_reg;
    // stage 2
    logic                 v2_reg, op2_reg, mode2_reg, few2_reg;
    logic [CRS_IDX_W-1:0] widx2_reg;
    crs_point_t           pt2_reg;
    logic [CRS_CNT_W-1:0] n2_reg, segs2_reg;
    logic [23:0]          scaled2_reg;
    // stage 3
    logic                 v3_reg;
    crs_ctl_t             ctl_reg;

    logic [CRS_T_W-1:0]   t_sat;
    logic [CRS_CNT_W-1:0] n_sat, segs;
    logic [23:0]          scaled_next;
    logic [7:0]           seg_raw, seg, s0, s3;
    logic [CRS_T_W-1:0]   u_next;
    crs_ctl_t             ctl_next;

    always_comb
    begin
        t_sat = (in_item.curve_t > T_ONE) ? T_ONE : in_item.curve_t;
        n_sat = (count > CRS_CNT_W'(CRS_MAX_POINTS)) ? CRS_CNT_W'(CRS_MAX_POINTS) : count;
        segs  = (mode1_reg == MODE_STANDARD) ? n1_reg - CRS_CNT_W'(3)
                                             : n1_reg - CRS_CNT_W'(1);
        scaled_next = 24'(t1_reg) * 24'(segs);
    end

    always_comb
    begin
        seg_raw = scaled2_reg[23:16];
        if (seg_raw >= 8'(segs2_reg))
        begin
            seg    = 8'(segs2_reg) - 8'd1;
            u_next = T_ONE;
        end
        else
        begin
            seg    = seg_raw;
            u_next = CRS_T_W'(scaled2_reg[15:0]);
        end
        s0 = (seg == 8'd0) ? seg : seg - 8'd1;
        s3 = ((seg + 8'd2) >= 8'(n2_reg)) ? seg + 8'd1 : seg + 8'd2;
        ctl_next.valid = v2_reg;
        ctl_next.wr    = (op2_reg == OP_WRITE);
        ctl_next.few   = few2_reg;
        ctl_next.widx  = widx2_reg;
        ctl_next.wdata = pt2_reg;
        ctl_next.u     = u_next;
        if (mode2_reg == MODE_STANDARD)
        begin
            ctl_next.ridx[0] = CRS_IDX_W'(seg);
            ctl_next.ridx[1] = CRS_IDX_W'(seg + 8'd1);
            ctl_next.ridx[2] = CRS_IDX_W'(seg + 8'd2);
            ctl_next.ridx[3] = CRS_IDX_W'(seg + 8'd3);
        end
        else
        begin
            ctl_next.ridx[0] = CRS_IDX_W'(s0);
            ctl_next.ridx[1] = CRS_IDX_W'(seg);
            ctl_next.ridx[2] = CRS_IDX_W'(seg + 8'd1);
            ctl_next.ridx[3] = CRS_IDX_W'(s3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= in_item.operation;
        mode1_reg <= mode;
        widx1_reg <= in_item.point_index;
        pt1_reg   <= '{x: in_item.coord_x, y: in_item.coord_y, z: in_item.coord_z};
        t1_reg    <= t_sat;
        n1_reg    <= n_sat;

        op2_reg     <= op1_reg;
        mode2_reg   <= mode1_reg;
        few2_reg    <= (n1_reg < CRS_CNT_W'(4));
        widx2_reg   <= widx1_reg;
        pt2_reg     <= pt1_reg;
        n2_reg      <= n1_reg;
        segs2_reg   <= segs;
        scaled2_reg <= scaled_next;

        ctl_reg <= ctl_next;
    end

    always_comb
    begin
        ctl       = ctl_reg;
        ctl.valid = v3_reg;
    end

endmodule

/* sv/crs_table.sv */
// ----------------------------------------------------------------------------
// Control point table
// Four copies of the point memory, one read port each, written together.
// ----------------------------------------------------------------------------
module crs_table
    import crs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  crs_ctl_t              ctl,
    output crs_point_t [3:0]      pts,
    output crs_rd_t               rd
);

    logic    v_reg;
    crs_rd_t rd_reg;

    for (genvar g = 0; g < 4; g++)
    begin : g_copy
        crs_point_t mem [CRS_MAX_POINTS];
        crs_point_t q_reg;

        always_ff @(posedge clk)
        begin
            if (ctl.valid && ctl.wr)
            begin
                mem[ctl.widx] <= ctl.wdata;
            end
            q_reg <= mem[ctl.ridx[g]];
        end

        assign pts[g] = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= ctl.valid && !ctl.wr;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg.valid <= 1'b0;
        rd_reg.few   <= ctl.few;
        rd_reg.u     <= ctl.u;
    end

    always_comb
    begin
        rd       = rd_reg;
        rd.valid = v_reg;
    end

endmodule

/* sv/crs_axis.sv */
// ----------------------------------------------------------------------------
// One-axis Horner pipeline
// Coefficients, then three multiply / round-add steps, then round and clamp.
// ----------------------------------------------------------------------------
module crs_axis
    import crs_pkg::*;
(
    input  logic                     clk,
    input  logic signed [31:0]       p0,
    input  logic signed [31:0]       p1,
    input  logic signed [31:0]       p2,
    input  logic signed [31:0]       p3,
    input  logic [CRS_T_W-1:0]       u,
    output logic signed [31:0]       pos
);

    localparam logic signed [CRS_COEF_W-1:0] THREE = CRS_COEF_W'(3);
    localparam logic signed [CRS_COEF_W-1:0] TWO   = CRS_COEF_W'(2);
    localparam logic signed [CRS_COEF_W-1:0] FOUR  = CRS_COEF_W'(4);
    localparam logic signed [CRS_COEF_W-1:0] FIVE  = CRS_COEF_W'(5);
    localparam logic signed [CRS_PROD_W-1:0] HALF  = CRS_PROD_W'(32768);
    localparam logic signed [CRS_COEF_W-1:0] S_MAX = CRS_COEF_W'(64'sd2147483647);
    localparam logic signed [CRS_COEF_W-1:0] S_MIN = -CRS_COEF_W'(64'sd2147483648);

    typedef logic signed [CRS_COEF_W-1:0] coef_t;
    typedef logic signed [CRS_PROD_W-1:0] prod_t;
    typedef logic signed [CRS_T_W:0]      us_t;

    coef_t q0, q1, q2, q3;
    coef_t e3_reg, e2_reg, e1_reg, e0_reg;
    coef_t e2_5_reg, e1_5_reg, e0_5_reg, a_reg, e1_7_reg, e0_7_reg, b_reg, e0_9_reg;
    coef_t e1_6_reg, e0_6_reg, e0_8_reg;
    us_t   u4_reg, u5_reg, u6_reg, u7_reg, u8_reg;
    prod_t prod1_reg, prod2_reg, prod3_reg;
    prod_t rnd1, rnd2, rnd3;
    coef_t c_w, r_w;
    logic signed [31:0] pos_reg;

    always_comb
    begin
        q0   = CRS_COEF_W'(p0);
        q1   = CRS_COEF_W'(p1);
        q2   = CRS_COEF_W'(p2);
        q3   = CRS_COEF_W'(p3);
        rnd1 = (prod1_reg + HALF) >>> 16;
        rnd2 = (prod2_reg + HALF) >>> 16;
        rnd3 = (prod3_reg + HALF) >>> 16;
        c_w  = CRS_COEF_W'(rnd3) + e0_9_reg;
        r_w  = (c_w + CRS_COEF_W'(1)) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        // coefficients
        e3_reg <= -q0 + THREE * q1 - THREE * q2 + q3;
        e2_reg <= TWO * q0 - FIVE * q1 + FOUR * q2 - q3;
        e1_reg <= q2 - q0;
        e0_reg <= TWO * q1;
        u4_reg <= us_t'({1'b0, u});
        // e3 * u
        prod1_reg <= CRS_PROD_W'(e3_reg) * CRS_PROD_W'(u4_reg);
        e2_5_reg  <= e2_reg;
        e1_5_reg  <= e1_reg;
        e0_5_reg  <= e0_reg;
        u5_reg    <= u4_reg;
        // a
        a_reg    <= CRS_COEF_W'(rnd1) + e2_5_reg;
        e1_6_reg <= e1_5_reg;
        e0_6_reg <= e0_5_reg;
        u6_reg   <= u5_reg;
        // a * u
        prod2_reg <= CRS_PROD_W'(a_reg) * CRS_PROD_W'(u6_reg);
        e1_7_reg  <= e1_6_reg;
        e0_7_reg  <= e0_6_reg;
        u7_reg    <= u6_reg;
        // b
        b_reg    <= CRS_COEF_W'(rnd2) + e1_7_reg;
        e0_8_reg <= e0_7_reg;
        u8_reg   <= u7_reg;
        // b * u
        prod3_reg <= CRS_PROD_W'(b_reg) * CRS_PROD_W'(u8_reg);
        e0_9_reg  <= e0_8_reg;
        // c, halve, clamp
        if (r_w > S_MAX)
        begin
            pos_reg <= 32'sh7FFFFFFF;
        end
        else if (r_w < S_MIN)
        begin
            pos_reg <= 32'sh80000000;
        end
        else
        begin
            pos_reg <= 32'(r_w);
        end
    end

    assign pos = pos_reg;

endmodule

/* sv/crs_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the evaluator's ports for result timing and status behavior.
// ----------------------------------------------------------------------------
`include "catmull_rom_spline_eval_macros.svh"

module crs_checker
    import crs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  crs_in_t              in_item,
    input  logic                 done,
    input  crs_out_t             result
);

    // one result for every evaluate transfer, fixed latency
    `CRS_ASSERT_IMP(a_done_latency, $past(rst_n, CRS_LATENCY), done == $past(start && !busy && in_item.operation == OP_EVAL, CRS_LATENCY), "done does not match evaluate transfer")
    `CRS_ASSERT_IMP(a_few_zero, done && result.status == STATUS_FEW, result.pos_x == 0 && result.pos_y == 0 && result.pos_z == 0, "short table result not zero")
    `CRS_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

bind catmull_rom_spline_eval crs_checker u_crs_checker (.*);
